// ----- hdl/brle_pkg.sv -----
// ----------------------------------------------------------------------------
// brle_pkg
// shared types and constants for the binary row run-length encoder
// ----------------------------------------------------------------------------
package brle_pkg;

  localparam int unsigned DefaultMaxRowWidth = 4096;

  localparam int unsigned PixW    = 8;
  localparam int unsigned LenW    = 13;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW    = 13;
  localparam int unsigned QDepth  = 4;

  localparam logic [PixW-1:0] ThresholdReset = 8'd100;
  localparam logic [LenW-1:0] RowWidthReset  = 13'd1024;

  typedef enum logic [CfgIdxW-1:0] {
    REG_WHITE_THRESHOLD = 2'd0,
    REG_ROW_WIDTH       = 2'd1
  } cfg_reg_t;

  typedef struct packed {
    logic [LenW-1:0] run_length;
    logic            run_white;
    logic            row_end;
    logic            blank_row;
  } run_res_t;

  // results produced by one pixel, first slot used before the second
  typedef struct packed {
    logic [1:0] count;
    run_res_t   first;
    run_res_t   second;
  } run_push_t;

  typedef struct packed {
    logic [PixW-1:0] white_threshold;
    logic [LenW-1:0] row_width;
  } brle_cfg_t;

endpackage

// ----- hdl/brle_if.sv -----
// ----------------------------------------------------------------------------
// brle channel interfaces
// pixel input, run output and configuration write channels
// ----------------------------------------------------------------------------
interface brle_pixel_if;
  logic                        valid;
  logic                        ready;
  logic [brle_pkg::PixW-1:0]   gray_pixel;

  modport source (output valid, output gray_pixel, input ready);
  modport sink (input valid, input gray_pixel, output ready);
endinterface

interface brle_run_if;
  logic                        valid;
  logic                        ready;
  logic [brle_pkg::LenW-1:0]   run_length;
  logic                        run_white;
  logic                        row_end;
  logic                        blank_row;

  modport source (output valid, output run_length, output run_white,
                  output row_end, output blank_row, input ready);
  modport sink (input valid, input run_length, input run_white,
                input row_end, input blank_row, output ready);
endinterface

interface brle_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [brle_pkg::CfgIdxW-1:0] index;
  logic [brle_pkg::CfgW-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ----- hdl/binary_row_run_length_encoder_unit.sv -----
// ----------------------------------------------------------------------------
// binary_row_run_length_encoder_unit
// run-length encoder for thresholded grayscale image rows
// ----------------------------------------------------------------------------
// usage:
//   pixel : gray pixels in raster order, valid/ready transactions
//   run   : finished runs (length, colour, row end, blank row flag)
//   cfg   : register writes, index 0 white threshold, index 1 row width;
//           write only while no pixel is in flight
// each pixel is classified and counted in the cycle it is accepted; the
// runs it ends are written to a four-entry result queue and shown on run
// from it. one pixel is taken per cycle while the queue has room. a pixel
// may end two runs (colour change on the last pixel of a row), those leave
// one per cycle. pixel.ready is high while the queue has room for two runs,
// so a stalled receiver holds pixels back once the queue fills; nothing is
// dropped. reset clears the run state, the queue, and sets threshold 100 and
// row width 1024 (clamped to MAX_ROW_WIDTH). cfg is always ready.
// ----------------------------------------------------------------------------
module binary_row_run_length_encoder_unit #(
  parameter int unsigned MAX_ROW_WIDTH = brle_pkg::DefaultMaxRowWidth
) (
  input  logic           clk,
  input  logic           rst,
  brle_pixel_if.sink     pixel,
  brle_run_if.source     run,
  brle_cfg_if.sink       cfg
);

  brle_pkg::brle_cfg_t cfg_regs;
  brle_pkg::run_push_t push;
  brle_pkg::run_res_t  out_res;
  logic                has_room;
  logic                pix_en;

  assign cfg.ready   = 1'b1;
  assign pixel.ready = has_room;
  assign pix_en      = pixel.valid && has_room;

  brle_cfg #(
    .MAX_ROW_WIDTH(MAX_ROW_WIDTH)
  ) u_cfg (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (cfg.valid),
    .wr_index(cfg.index),
    .wr_data (cfg.data),
    .cfg     (cfg_regs)
  );

  brle_core #(
    .MAX_ROW_WIDTH(MAX_ROW_WIDTH)
  ) u_core (
    .clk   (clk),
    .rst   (rst),
    .pix_en(pix_en),
    .pix   (pixel.gray_pixel),
    .cfg   (cfg_regs),
    .push  (push)
  );

  brle_outq u_outq (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .has_room (has_room),
    .out_valid(run.valid),
    .out_ready(run.ready),
    .out_res  (out_res)
  );

  assign run.run_length = out_res.run_length;
  assign run.run_white  = out_res.run_white;
  assign run.row_end    = out_res.row_end;
  assign run.blank_row  = out_res.blank_row;

endmodule

// ----- hdl/brle_cfg.sv -----
// ----------------------------------------------------------------------------
// brle_cfg
// configuration registers, row width kept in its clamped form
// ----------------------------------------------------------------------------
module brle_cfg #(
  parameter int unsigned MAX_ROW_WIDTH = brle_pkg::DefaultMaxRowWidth
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        wr_en,
  input  logic [brle_pkg::CfgIdxW-1:0] wr_index,
  input  logic [brle_pkg::CfgW-1:0]   wr_data,
  output brle_pkg::brle_cfg_t         cfg
);

  localparam int unsigned LenW = brle_pkg::LenW;
  localparam int unsigned LenMax = (1 << LenW) - 1;
  localparam logic [LenW-1:0] MaxW =
    (MAX_ROW_WIDTH > LenMax) ? LenW'(LenMax) : LenW'(MAX_ROW_WIDTH);
  localparam logic [LenW-1:0] WidthReset =
    (brle_pkg::RowWidthReset > MaxW) ? MaxW : brle_pkg::RowWidthReset;

  logic [LenW-1:0] width_clamped;

  always_comb begin
    if (wr_data[LenW-1:0] == '0) begin
      width_clamped = LenW'(1);
    end else if (wr_data[LenW-1:0] > MaxW) begin
      width_clamped = MaxW;
    end else begin
      width_clamped = wr_data[LenW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.white_threshold <= brle_pkg::ThresholdReset;
      cfg.row_width       <= WidthReset;
    end else if (wr_en) begin
      case (brle_pkg::cfg_reg_t'(wr_index))
        brle_pkg::REG_WHITE_THRESHOLD: begin
          cfg.white_threshold <= wr_data[brle_pkg::PixW-1:0];
        end
        brle_pkg::REG_ROW_WIDTH: begin
          cfg.row_width <= width_clamped;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ----- hdl/brle_core.sv -----
// ----------------------------------------------------------------------------
// brle_core
// thresholding and run tracking, one pixel per cycle while pix_en is high
// ----------------------------------------------------------------------------
module brle_core #(
  parameter int unsigned MAX_ROW_WIDTH = brle_pkg::DefaultMaxRowWidth
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      pix_en,
  input  logic [brle_pkg::PixW-1:0] pix,
  input  brle_pkg::brle_cfg_t       cfg,
  output brle_pkg::run_push_t       push
);

  localparam int unsigned LenW = brle_pkg::LenW;
  localparam int unsigned LenMax = (1 << LenW) - 1;
  localparam int unsigned EffMax = (MAX_ROW_WIDTH > LenMax) ? LenMax : MAX_ROW_WIDTH;
  localparam int unsigned ColW = $clog2(EffMax);

  logic [ColW-1:0] column_position;
  logic [LenW-1:0] current_run_length;
  logic            current_colour;

  logic [ColW-1:0] column_position_next;
  logic [LenW-1:0] current_run_length_next;
  logic            current_colour_next;

  logic            white;
  logic            change;
  logic            row_done;
  logic [LenW-1:0] col_plus;
  logic [LenW-1:0] len_upd;
  logic            colour_upd;
  brle_pkg::run_res_t res_change;
  brle_pkg::run_res_t res_end;

  always_comb begin
    white    = pix > cfg.white_threshold;
    col_plus = LenW'(column_position) + LenW'(1);
    row_done = col_plus >= cfg.row_width;
    change   = 1'b0;

    if (current_run_length == '0) begin
      colour_upd = white;
      len_upd    = LenW'(1);
    end else if (white != current_colour) begin
      change     = 1'b1;
      colour_upd = white;
      len_upd    = LenW'(1);
    end else begin
      colour_upd = current_colour;
      len_upd    = current_run_length + LenW'(1);
    end

    res_change.run_length = current_run_length;
    res_change.run_white  = current_colour;
    res_change.row_end    = 1'b0;
    res_change.blank_row  = 1'b0;

    res_end.run_length = len_upd;
    res_end.run_white  = colour_upd;
    res_end.row_end    = 1'b1;
    res_end.blank_row  = colour_upd && (len_upd == col_plus);

    push.first  = change ? res_change : res_end;
    push.second = res_end;
    if (!pix_en) begin
      push.count = 2'd0;
    end else begin
      push.count = 2'(change) + 2'(row_done);
    end

    if (row_done) begin
      column_position_next    = '0;
      current_run_length_next = '0;
    end else begin
      column_position_next    = col_plus[ColW-1:0];
      current_run_length_next = len_upd;
    end
    current_colour_next = colour_upd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_position    <= '0;
      current_run_length <= '0;
      current_colour     <= 1'b0;
    end else if (pix_en) begin
      column_position    <= column_position_next;
      current_run_length <= current_run_length_next;
      current_colour     <= current_colour_next;
    end
  end

endmodule

// ----- hdl/brle_outq.sv -----
// ----------------------------------------------------------------------------
// brle_outq
// result queue, takes up to two runs per cycle and hands out one while out_ready
// ----------------------------------------------------------------------------
module brle_outq (
  input  logic                clk,
  input  logic                rst,
  input  brle_pkg::run_push_t push,
  output logic                has_room,
  output logic                out_valid,
  input  logic                out_ready,
  output brle_pkg::run_res_t  out_res
);

  localparam int unsigned Depth = brle_pkg::QDepth;
  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = PtrW + 1;

  brle_pkg::run_res_t mem [Depth];

  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic [PtrW-1:0] wr_ptr_next;
  logic [PtrW-1:0] rd_ptr_next;
  logic [CntW-1:0] count_next;
  logic            pop;

  always_comb begin
    out_valid   = count != '0;
    pop         = out_valid && out_ready;
    has_room    = count <= CntW'(Depth - 2);
    out_res     = mem[rd_ptr];
    wr_ptr_next = wr_ptr + PtrW'(push.count);
    rd_ptr_next = rd_ptr + PtrW'(pop);
    count_next  = count + CntW'(push.count) - CntW'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem[wr_ptr] <= push.first;
    end
    if (push.count == 2'd2) begin
      mem[wr_ptr + PtrW'(1)] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      count  <= count_next;
    end
  end

endmodule

// ----- hdl/brle_checker.sv -----
// ----------------------------------------------------------------------------
// brle_checker
// port-level checks for the run-length encoder
// ----------------------------------------------------------------------------
module brle_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      run_valid,
  input logic                      run_ready,
  input logic [brle_pkg::LenW-1:0] run_length,
  input logic                      run_white,
  input logic                      row_end,
  input logic                      blank_row
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !run_valid)
    else $error("run output valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    run_valid && !run_ready |=> run_valid && $stable(run_length) &&
    $stable(run_white) && $stable(row_end) && $stable(blank_row))
    else $error("stalled run transaction changed");

  a_blank: assert property (@(posedge clk) disable iff (rst)
    run_valid && blank_row |-> row_end && run_white)
    else $error("blank row flag on a run that is not a white row end");

  a_len: assert property (@(posedge clk) disable iff (rst)
    run_valid |-> run_length != '0)
    else $error("run of zero length");

endmodule

bind binary_row_run_length_encoder_unit brle_checker u_brle_checker (
  .clk       (clk),
  .rst       (rst),
  .run_valid (run.valid),
  .run_ready (run.ready),
  .run_length(run.run_length),
  .run_white (run.run_white),
  .row_end   (run.row_end),
  .blank_row (run.blank_row)
);

// ----- tb/brle_run_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brle_run_checker
// watches the pixel, run and register channels of the run-length encoder,
// predicts the runs each accepted pixel closes and compares every accepted
// run field by field against the oldest predicted one
// ----------------------------------------------------------------------------
module brle_run_checker
  import brle_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  brle_pixel_if       pixel,
  brle_run_if         run,
  brle_cfg_if         cfg,
  output int unsigned mismatch_count,
  output int unsigned runs_outstanding
);

  logic [PixW-1:0] threshold;
  logic [LenW-1:0] width_reg;
  logic [11:0]     column;
  logic [LenW-1:0] run_len;
  logic            run_is_white;
  run_res_t        expected_runs[$];
  run_res_t        want;
  int unsigned     fail_total = 0;

  function automatic logic [LenW-1:0] clamp_width(input logic [LenW-1:0] w);
    if (w == '0) return LenW'(1);
    if (w > LenW'(DefaultMaxRowWidth)) return LenW'(DefaultMaxRowWidth);
    return w;
  endfunction

  task automatic note_failure(input string what);
    fail_total++;
    if (fail_total <= 10) $display("%0t: %s", $realtime, what);
  endtask

  // classify one pixel and queue the runs it closes
  task automatic encode_pixel(input logic [PixW-1:0] gray);
    logic     white;
    run_res_t closed;
    white = gray > threshold;
    if (run_len == '0) begin
      run_is_white = white;
      run_len = LenW'(1);
    end else if (white != run_is_white) begin
      closed = '{run_length: run_len, run_white: run_is_white, row_end: 1'b0,
                 blank_row: 1'b0};
      expected_runs.push_back(closed);
      run_is_white = white;
      run_len = LenW'(1);
    end else begin
      run_len = run_len + 1'b1;
    end
    if ({1'b0, column} + 13'd1 >= clamp_width(width_reg)) begin
      closed = '{run_length: run_len, run_white: run_is_white, row_end: 1'b1,
                 blank_row: run_is_white && (run_len == {1'b0, column} + 13'd1)};
      expected_runs.push_back(closed);
      column = '0;
      run_len = '0;
    end else begin
      column = column + 1'b1;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      threshold = ThresholdReset;
      width_reg = RowWidthReset;
      column = '0;
      run_len = '0;
      run_is_white = 1'b0;
      expected_runs.delete();
    end else begin
      if (run.valid && run.ready) begin
        if (expected_runs.size() == 0) begin
          note_failure($sformatf("unexpected run: len=%0d white=%b end=%b blank=%b",
                                 run.run_length, run.run_white, run.row_end,
                                 run.blank_row));
        end else begin
          want = expected_runs.pop_front();
          if (run.run_length !== want.run_length || run.run_white !== want.run_white ||
              run.row_end !== want.row_end || run.blank_row !== want.blank_row) begin
            note_failure($sformatf(
              "run mismatch: expected len=%0d white=%b end=%b blank=%b, got len=%0d white=%b end=%b blank=%b",
              want.run_length, want.run_white, want.row_end, want.blank_row,
              run.run_length, run.run_white, run.row_end, run.blank_row));
          end
        end
      end
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_WHITE_THRESHOLD: threshold = cfg.data[PixW-1:0];
          REG_ROW_WIDTH:       width_reg = cfg.data[LenW-1:0];
          default: ;
        endcase
      end
      if (pixel.valid && pixel.ready) encode_pixel(pixel.gray_pixel);
    end
    mismatch_count   <= fail_total;
    runs_outstanding <= expected_runs.size();
  end

endmodule

// ----- tb/tb_binary_row_run_length_encoder_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_binary_row_run_length_encoder_unit
// drives thresholded pixel rows through the run-length encoder: a directed
// set of corner cases, a long blank row, a long receiver stall, then
// random register settings with run-shaped pixel streams; a side checker
// predicts and compares every run, this module gives the verdict
// ----------------------------------------------------------------------------
module tb_binary_row_run_length_encoder_unit;
  import brle_pkg::*;

  localparam logic [CfgIdxW-1:0] RegSpareA = 2'd2;
  localparam logic [CfgIdxW-1:0] RegSpareB = 2'd3;
  localparam logic [CfgW-1:0]    WidthFieldMax = '1;
  localparam int unsigned IdlePct      = 8;
  localparam int unsigned HoldCycles   = 300;
  localparam int unsigned SettleCycles = 4;
  localparam int unsigned BlankPixels  = 400;
  localparam int unsigned RandomPixels = 1300;

  logic        clk;
  logic        rst;
  int unsigned mismatch_count;
  int unsigned runs_outstanding;
  bit          idle_en;
  int unsigned hold_requests;
  int unsigned hold_served;
  int unsigned random_sent;
  logic [PixW-1:0] cur_threshold;
  logic [CfgW-1:0] next_width;
  logic [PixW-1:0] next_thr;
  int unsigned     pick;

  brle_pixel_if pix_if();
  brle_run_if   run_if();
  brle_cfg_if   cfg_if();

  binary_row_run_length_encoder_unit DUT (
    .clk   (clk),
    .rst   (rst),
    .pixel (pix_if),
    .run   (run_if),
    .cfg   (cfg_if)
  );

  brle_run_checker u_checker (
    .clk              (clk),
    .rst              (rst),
    .pixel            (pix_if),
    .run              (run_if),
    .cfg              (cfg_if),
    .mismatch_count   (mismatch_count),
    .runs_outstanding (runs_outstanding)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  initial begin
    #400000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // run receiver with random stalls and requested long hold-offs
  initial begin
    hold_served = 0;
    run_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_served != hold_requests) begin
        hold_served++;
        run_if.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
      end
      run_if.ready <= !(idle_en && $urandom_range(99) < IdlePct);
    end
  end

  task automatic send_pixel(input logic [PixW-1:0] gray);
    while (idle_en && $urandom_range(99) < IdlePct) begin
      pix_if.valid <= 1'b0;
      @(posedge clk);
    end
    pix_if.valid      <= 1'b1;
    pix_if.gray_pixel <= gray;
    do @(posedge clk); while (!pix_if.ready);
  endtask

  task automatic quiesce();
    pix_if.valid <= 1'b0;
    do @(posedge clk); while (runs_outstanding != 0);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    do @(posedge clk); while (!cfg_if.ready);
    if (idx == REG_WHITE_THRESHOLD) cur_threshold = value[PixW-1:0];
  endtask

  task automatic apply_config(input bit set_thr, input logic [PixW-1:0] thr,
                              input bit set_width, input logic [CfgW-1:0] width,
                              input bit spare);
    quiesce();
    if (set_thr) write_reg(REG_WHITE_THRESHOLD, CfgW'(thr));
    if (set_width) write_reg(REG_ROW_WIDTH, width);
    if (spare) begin
      write_reg(RegSpareA, CfgW'($urandom()));
      write_reg(RegSpareB, CfgW'($urandom()));
    end
    cfg_if.valid <= 1'b0;
  endtask

  // pixel value on the requested side of the threshold, often right at it
  function automatic logic [PixW-1:0] shade(input bit white);
    if (white && cur_threshold != 8'hFF) begin
      if ($urandom_range(3) == 0) return cur_threshold + 1'b1;
      return PixW'($urandom_range(255, int'(cur_threshold) + 1));
    end
    if ($urandom_range(3) == 0) return cur_threshold;
    return PixW'($urandom_range(int'(cur_threshold), 0));
  endfunction

  task automatic random_phase(input int unsigned n_pixels);
    int unsigned left;
    int unsigned run_left;
    bit          color;
    left = n_pixels;
    while (left > 0) begin
      color = 1'($urandom_range(1));
      run_left = ($urandom_range(3) == 0) ? $urandom_range(20, 1) : $urandom_range(4, 1);
      while (run_left > 0 && left > 0) begin
        if ($urandom_range(99) < 15) send_pixel(PixW'($urandom_range(255)));
        else send_pixel(shade(color));
        run_left--;
        left--;
        random_sent++;
      end
    end
  endtask

  initial begin
    rst               <= 1'b1;
    pix_if.valid      <= 1'b0;
    pix_if.gray_pixel <= '0;
    cfg_if.valid      <= 1'b0;
    cfg_if.index      <= REG_WHITE_THRESHOLD;
    cfg_if.data       <= '0;
    idle_en       = 1'b1;
    hold_requests = 0;
    random_sent   = 0;
    cur_threshold = ThresholdReset;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // reset threshold, colour changes inside a wide row
    send_pixel(8'd100); send_pixel(8'd101); send_pixel(8'd0);
    send_pixel(8'd255); send_pixel(8'd255); send_pixel(8'd99);
    // width cut below the current column, unused register indexes
    apply_config(1'b0, 8'd0, 1'b1, 13'd5, 1'b1);
    send_pixel(8'd200);
    // width zero acts as one pixel rows
    apply_config(1'b1, 8'd0, 1'b1, 13'd0, 1'b0);
    send_pixel(8'd0); send_pixel(8'd1); send_pixel(8'd255);
    // threshold at top: nothing is white
    apply_config(1'b1, 8'd255, 1'b1, 13'd4, 1'b0);
    send_pixel(8'd255); send_pixel(8'd128); send_pixel(8'd0); send_pixel(8'd255);
    // blank row, then a color change on the last pixel
    apply_config(1'b1, 8'd127, 1'b1, 13'd3, 1'b0);
    send_pixel(8'd128); send_pixel(8'd255); send_pixel(8'd200);
    send_pixel(8'd127); send_pixel(8'd127); send_pixel(8'd128);
    // saturated width, then shrunk mid-row
    apply_config(1'b1, 8'd100, 1'b1, WidthFieldMax, 1'b0);
    send_pixel(8'd255); send_pixel(8'd0);
    apply_config(1'b0, 8'd0, 1'b1, 13'd2, 1'b0);
    send_pixel(8'd0);

    // long blank row at the saturated width, no idling, closed by a width cut
    apply_config(1'b0, 8'd0, 1'b1, 13'd1, 1'b0);
    send_pixel(8'd0);
    apply_config(1'b1, 8'd0, 1'b1, WidthFieldMax, 1'b0);
    idle_en = 1'b0;
    repeat (BlankPixels) send_pixel(PixW'($urandom_range(255, 1)));
    apply_config(1'b0, 8'd0, 1'b1, 13'd1, 1'b0);
    send_pixel(8'd255);
    apply_config(1'b0, 8'd0, 1'b1, 13'd4096, 1'b0);
    idle_en = 1'b1;

    // one run per pixel while the receiver holds off
    apply_config(1'b1, 8'd127, 1'b1, 13'd1, 1'b0);
    hold_requests++;
    random_phase(48);

    while (random_sent < RandomPixels) begin
      pick = $urandom_range(9);
      next_thr = (pick == 0) ? 8'd0 : (pick == 1) ? 8'd255 : PixW'($urandom());
      pick = $urandom_range(19);
      if (pick == 0) next_width = '0;
      else if (pick == 1) next_width = CfgW'($urandom_range(8191, 4097));
      else if (pick == 2) next_width = 13'd4096;
      else if (pick < 9) next_width = CfgW'($urandom_range(4, 1));
      else next_width = CfgW'($urandom_range(24, 5));
      apply_config(1'($urandom_range(1)), next_thr, $urandom_range(3) != 0, next_width,
                   $urandom_range(15) == 0);
      random_phase($urandom_range(60, 8));
    end

    quiesce();
    if (mismatch_count == 0 && runs_outstanding == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
